>>> rtl/lcw_pkg.sv
// shared types and constants for the line clip-to-window block
`default_nettype none

package lcw_pkg;

    // coordinate and fixed-point sizes
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // edge moves allowed before a segment is given up
    localparam int MAX_MOVES = 4;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = COORD_BITS;

    // window after reset
    localparam logic signed [COORD_BITS-1:0] WINDOW_LEFT_RESET   = COORD_BITS'(120);
    localparam logic signed [COORD_BITS-1:0] WINDOW_BOTTOM_RESET = COORD_BITS'(110);
    localparam logic signed [COORD_BITS-1:0] WINDOW_RIGHT_RESET  = COORD_BITS'(360);
    localparam logic signed [COORD_BITS-1:0] WINDOW_TOP_RESET    = COORD_BITS'(280);

    // outcode bits
    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_BELOW  = 4'b0100;
    localparam logic [3:0] OC_ABOVE  = 4'b1000;
    localparam logic [3:0] OC_INSIDE = 4'b0000;

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WINDOW_LEFT   = 2'd0,
        REG_WINDOW_BOTTOM = 2'd1,
        REG_WINDOW_RIGHT  = 2'd2,
        REG_WINDOW_TOP    = 2'd3
    } cfg_index_t;

    // one segment in
    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } seg_t;

    // one clipped segment out
    typedef struct packed {
        logic                         accepted;
        logic signed [COORD_BITS-1:0] clipped_start_x;
        logic signed [COORD_BITS-1:0] clipped_start_y;
        logic signed [COORD_BITS-1:0] clipped_end_x;
        logic signed [COORD_BITS-1:0] clipped_end_y;
    } result_t;

    // clipping sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_SETUP,
        ST_WAIT
    } clip_state_t;

    // serial multiply-divide unit
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

endpackage

`default_nettype wire

>>> rtl/lcw_muldiv.sv
// bit-serial unit for trunc(a * b / d): shift-add multiply, then restoring divide
`default_nettype none

module lcw_muldiv #(
    parameter int AW = 52,
    parameter int MW = 16,
    parameter int QW = 51
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  go,
    input  wire signed [AW-1:0]  a,
    input  wire signed [MW:0]    b,
    input  wire signed [MW:0]    d,
    output logic                 done,
    output logic                 neg,
    output logic [QW-1:0]        quot
);

    localparam int PW = AW + MW;
    localparam int CW = $clog2(PW);

    lcw_pkg::md_state_t state_reg, state_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [AW-1:0]      mcand_reg, mcand_next;
    logic [MW-1:0]      div_reg, div_next;
    logic [MW-1:0]      rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;

    // operand magnitudes
    logic [AW-1:0] a_mag;
    logic [MW:0]   b_abs;
    logic [MW:0]   d_abs;

    // datapath pieces
    logic [AW:0]   mul_sum;
    logic [MW:0]   trial;
    logic          fits;

    assign a_mag = a[AW-1] ? (~a + AW'(1)) : a;
    assign b_abs = b[MW] ? (~b + (MW+1)'(1)) : b;
    assign d_abs = d[MW] ? (~d + (MW+1)'(1)) : d;

    // one multiplier bit per cycle, high half accumulates
    assign mul_sum = {1'b0, p_reg[PW-1:MW]} + {1'b0, (p_reg[0] ? mcand_reg : '0)};

    // one quotient bit per cycle
    assign trial = {rem_reg, p_reg[PW-1]};
    assign fits  = trial >= {1'b0, div_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcw_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
    end

    // sequencing and datapath updates
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            lcw_pkg::MD_IDLE:
            begin
                if (go)
                begin
                    p_next     = {{AW{1'b0}}, b_abs[MW-1:0]};
                    mcand_next = a_mag;
                    div_next   = d_abs[MW-1:0];
                    neg_next   = a[AW-1] ^ b[MW] ^ d[MW];
                    cnt_next   = CW'(MW - 1);
                    state_next = lcw_pkg::MD_MUL;
                end
            end

            lcw_pkg::MD_MUL:
            begin
                p_next = {mul_sum, p_reg[MW-1:1]};
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = CW'(PW - 1);
                    state_next = lcw_pkg::MD_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            lcw_pkg::MD_DIV:
            begin
                // remainder stays below the divisor, so the top bit is always clear
                rem_next = fits ? MW'(trial - {1'b0, div_reg}) : trial[MW-1:0];
                p_next   = {p_reg[PW-2:0], fits};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = lcw_pkg::MD_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            default:
            begin
                state_next = lcw_pkg::MD_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign quot = p_reg[QW-1:0];

endmodule

`default_nettype wire

>>> rtl/line_clip_to_window.sv
// line clip-to-window top level: outcode tests, edge moves and result register
// Flow: the start transfer loads ST_TEST, which accepts, rejects or starts an edge move; a move
//   goes through ST_SETUP and back to ST_TEST when the segment runs parallel to the edge, and
//   through ST_WAIT for the serial unit otherwise (XW = 2*COORD_BITS + FRAC_BITS + 3), up to 4 moves.
// One segment at a time; the next start is taken in the cycle done is high.
//   A sloped move waits on the bit-serial multiply and the one-bit-per-cycle divider.
// Reset: window returns to left 120, bottom 110, right 360, top 280; block comes up idle.
`default_nettype none

module line_clip_to_window #(
    parameter int FRAC_BITS = lcw_pkg::FRAC_BITS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire lcw_pkg::seg_t                   seg,
    output logic                                 done,
    output lcw_pkg::result_t                     result,
    input  wire                                  cfg_we,
    input  wire  [lcw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire  [lcw_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int C   = lcw_pkg::COORD_BITS;
    localparam int XW  = 2 * C + FRAC_BITS + 3;
    localparam int IW  = XW - FRAC_BITS;
    localparam int AW  = XW + 1;
    localparam int MVW = $clog2(lcw_pkg::MAX_MOVES + 1);

    // coordinate to fixed point
    function automatic logic signed [XW-1:0] to_fixed(input logic signed [C-1:0] v);
        to_fixed = {{(XW - C - FRAC_BITS){v[C-1]}}, v, {FRAC_BITS{1'b0}}};
    endfunction

    // fixed point to integer, rounding toward zero
    function automatic logic signed [IW-1:0] trunc_int(input logic signed [XW-1:0] v);
        logic signed [IW-1:0] ip;
        ip = v[XW-1:FRAC_BITS];
        if (v[XW-1] && (|v[FRAC_BITS-1:0]))
        begin
            trunc_int = ip + IW'(1);
        end
        else
        begin
            trunc_int = ip;
        end
    endfunction

    // window registers
    logic signed [C-1:0] win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;

    // sequencer and working registers
    lcw_pkg::clip_state_t  state_reg, state_next;
    logic signed [XW-1:0]  x1_reg, x1_next, y1_reg, y1_next;
    logic signed [XW-1:0]  x2_reg, x2_next, y2_reg, y2_next;
    logic signed [C:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic [MVW-1:0]        moves_reg, moves_next;
    logic [3:0]            code_reg, code_next;
    logic                  target_y_reg, target_y_next;
    logic signed [AW-1:0]  a_reg, a_next;
    logic                  go_reg, go_next;
    logic                  done_reg, done_next;
    lcw_pkg::result_t      result_reg, result_next;

    // window in integer-part width
    logic signed [IW-1:0]  wl_ext, wb_ext, wr_ext, wt_ext;

    // endpoint integer parts and outcodes
    logic signed [IW-1:0]  xi1, yi1, xi2, yi2;
    logic [3:0]            c1, c2;

    // edge targets
    logic signed [XW-1:0]  edge_x, edge_y;

    // serial unit hookup
    logic signed [C:0]     md_b, md_d;
    logic                  md_done, md_neg;
    logic [XW-1:0]         md_quot;
    logic [XW-1:0]         delta_bits;

    assign wl_ext = {{(IW - C){win_left_reg[C-1]}}, win_left_reg};
    assign wb_ext = {{(IW - C){win_bottom_reg[C-1]}}, win_bottom_reg};
    assign wr_ext = {{(IW - C){win_right_reg[C-1]}}, win_right_reg};
    assign wt_ext = {{(IW - C){win_top_reg[C-1]}}, win_top_reg};

    assign xi1 = trunc_int(x1_reg);
    assign yi1 = trunc_int(y1_reg);
    assign xi2 = trunc_int(x2_reg);
    assign yi2 = trunc_int(y2_reg);

    // outcodes of both endpoints
    always_comb
    begin
        c1 = lcw_pkg::OC_INSIDE;
        c2 = lcw_pkg::OC_INSIDE;
        if (xi1 < wl_ext) c1 |= lcw_pkg::OC_LEFT;
        if (xi1 > wr_ext) c1 |= lcw_pkg::OC_RIGHT;
        if (yi1 < wb_ext) c1 |= lcw_pkg::OC_BELOW;
        if (yi1 > wt_ext) c1 |= lcw_pkg::OC_ABOVE;
        if (xi2 < wl_ext) c2 |= lcw_pkg::OC_LEFT;
        if (xi2 > wr_ext) c2 |= lcw_pkg::OC_RIGHT;
        if (yi2 < wb_ext) c2 |= lcw_pkg::OC_BELOW;
        if (yi2 > wt_ext) c2 |= lcw_pkg::OC_ABOVE;
    end

    assign edge_x = ((code_reg & lcw_pkg::OC_LEFT) != lcw_pkg::OC_INSIDE) ?
                    to_fixed(win_left_reg) : to_fixed(win_right_reg);
    assign edge_y = ((code_reg & lcw_pkg::OC_BELOW) != lcw_pkg::OC_INSIDE) ?
                    to_fixed(win_bottom_reg) : to_fixed(win_top_reg);

    // slope terms for the moved coordinate
    assign md_b = target_y_reg ? dy_reg : dx_reg;
    assign md_d = target_y_reg ? dx_reg : dy_reg;

    // signed quotient as ones complement, carry-in added with the coordinate
    assign delta_bits = md_quot ^ {XW{md_neg}};

    lcw_muldiv #(
        .AW (AW),
        .MW (C),
        .QW (XW)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .a     (a_reg),
        .b     (md_b),
        .d     (md_d),
        .done  (md_done),
        .neg   (md_neg),
        .quot  (md_quot)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= lcw_pkg::WINDOW_LEFT_RESET;
            win_bottom_reg <= lcw_pkg::WINDOW_BOTTOM_RESET;
            win_right_reg  <= lcw_pkg::WINDOW_RIGHT_RESET;
            win_top_reg    <= lcw_pkg::WINDOW_TOP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcw_pkg::REG_WINDOW_LEFT:   win_left_reg   <= cfg_data[C-1:0];
                lcw_pkg::REG_WINDOW_BOTTOM: win_bottom_reg <= cfg_data[C-1:0];
                lcw_pkg::REG_WINDOW_RIGHT:  win_right_reg  <= cfg_data[C-1:0];
                lcw_pkg::REG_WINDOW_TOP:    win_top_reg    <= cfg_data[C-1:0];
                default:                    win_top_reg    <= win_top_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcw_pkg::ST_IDLE;
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            done_reg  <= done_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        x1_reg       <= x1_next;
        y1_reg       <= y1_next;
        x2_reg       <= x2_next;
        y2_reg       <= y2_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        moves_reg    <= moves_next;
        code_reg     <= code_next;
        target_y_reg <= target_y_next;
        a_reg        <= a_next;
        result_reg   <= result_next;
    end

    // clipping sequencer
    always_comb
    begin
        state_next    = state_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        x2_next       = x2_reg;
        y2_next       = y2_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        moves_next    = moves_reg;
        code_next     = code_reg;
        target_y_next = target_y_reg;
        a_next        = a_reg;
        result_next   = result_reg;
        go_next       = 1'b0;
        done_next     = 1'b0;

        unique case (state_reg)
            lcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    x1_next    = to_fixed(seg.start_x);
                    y1_next    = to_fixed(seg.start_y);
                    x2_next    = to_fixed(seg.end_x);
                    y2_next    = to_fixed(seg.end_y);
                    dx_next    = {seg.end_x[C-1], seg.end_x} - {seg.start_x[C-1], seg.start_x};
                    dy_next    = {seg.end_y[C-1], seg.end_y} - {seg.start_y[C-1], seg.start_y};
                    moves_next = '0;
                    state_next = lcw_pkg::ST_TEST;
                end
            end

            lcw_pkg::ST_TEST:
            begin
                priority if (c1 == lcw_pkg::OC_INSIDE && c2 == lcw_pkg::OC_INSIDE)
                begin
                    result_next.accepted        = 1'b1;
                    result_next.clipped_start_x = xi1[C-1:0];
                    result_next.clipped_start_y = yi1[C-1:0];
                    result_next.clipped_end_x   = xi2[C-1:0];
                    result_next.clipped_end_y   = yi2[C-1:0];
                    done_next  = 1'b1;
                    state_next = lcw_pkg::ST_IDLE;
                end
                else if ((c1 & c2) != lcw_pkg::OC_INSIDE ||
                         moves_reg == MVW'(lcw_pkg::MAX_MOVES))
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    state_next  = lcw_pkg::ST_IDLE;
                end
                else
                begin
                    moves_next = moves_reg + MVW'(1);
                    // inside first endpoint trades places with the second
                    if (c1 == lcw_pkg::OC_INSIDE)
                    begin
                        x1_next   = x2_reg;
                        y1_next   = y2_reg;
                        x2_next   = x1_reg;
                        y2_next   = y1_reg;
                        code_next = c2;
                    end
                    else
                    begin
                        code_next = c1;
                    end
                    state_next = lcw_pkg::ST_SETUP;
                end
            end

            lcw_pkg::ST_SETUP:
            begin
                if ((code_reg & (lcw_pkg::OC_LEFT | lcw_pkg::OC_RIGHT)) != lcw_pkg::OC_INSIDE)
                begin
                    // vertical edge: x snaps, y follows the slope
                    a_next        = {edge_x[XW-1], edge_x} - {x1_reg[XW-1], x1_reg};
                    x1_next       = edge_x;
                    target_y_next = 1'b1;
                    if (dx_reg == '0)
                    begin
                        state_next = lcw_pkg::ST_TEST;
                    end
                    else
                    begin
                        go_next    = 1'b1;
                        state_next = lcw_pkg::ST_WAIT;
                    end
                end
                else
                begin
                    // horizontal edge: y snaps, x follows the slope
                    a_next        = {edge_y[XW-1], edge_y} - {y1_reg[XW-1], y1_reg};
                    y1_next       = edge_y;
                    target_y_next = 1'b0;
                    if (dy_reg == '0)
                    begin
                        state_next = lcw_pkg::ST_TEST;
                    end
                    else
                    begin
                        go_next    = 1'b1;
                        state_next = lcw_pkg::ST_WAIT;
                    end
                end
            end

            lcw_pkg::ST_WAIT:
            begin
                if (md_done)
                begin
                    if (target_y_reg)
                    begin
                        y1_next = y1_reg + $signed(delta_bits) + $signed({1'b0, md_neg});
                    end
                    else
                    begin
                        x1_next = x1_reg + $signed(delta_bits) + $signed({1'b0, md_neg});
                    end
                    state_next = lcw_pkg::ST_TEST;
                end
            end

            default:
            begin
                state_next = lcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != lcw_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a result transfer always leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == lcw_pkg::ST_IDLE)
        else $error("result strobe while sequencer is not idle");

    // a move in progress holds until the serial unit finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcw_pkg::ST_WAIT && !md_done) |=> state_reg == lcw_pkg::ST_WAIT)
        else $error("sequencer left the wait state early");

    // the serial unit is only launched on entry to the wait state
    assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |-> state_reg == lcw_pkg::ST_WAIT)
        else $error("serial unit launched outside a move");

    // a rejected segment carries zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.accepted) |->
        (result_reg.clipped_start_x == '0 && result_reg.clipped_start_y == '0 &&
         result_reg.clipped_end_x == '0 && result_reg.clipped_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

endmodule

`default_nettype wire
